// File: hdl/lrhp_pkg.sv
// Package for the literal run header packer.
// Holds the payload, configuration and queue entry types, the register
// indexes and the header bit mapping function. No dependencies.
package lrhp_pkg;

	localparam int MAX_HEADER_BYTES = 4;
	localparam int LENGTH_WIDTH     = 16;
	localparam int HDR_CNT_W        = $clog2(MAX_HEADER_BYTES + 1);
	localparam int QUEUE_DEPTH      = 4;
	localparam int QPTR_W           = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W           = $clog2(QUEUE_DEPTH + 1);
	localparam int MAP_W            = 40;
	localparam int CFG_INDEX_W      = 4;
	localparam int CFG_DATA_W       = 40;

	localparam logic [4:0] CODE_ONE = 5'd31;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_LENGTH_BITS       = 4'd0,
		REG_LENGTH_OFFSET     = 4'd1,
		REG_ALIGN_BITS        = 4'd2,
		REG_HEADER_BYTES      = 4'd3,
		REG_HEADER_MAP_FIRST  = 4'd4,
		REG_HEADER_MAP_SECOND = 4'd5,
		REG_HEADER_MAP_THIRD  = 4'd6,
		REG_HEADER_MAP_FOURTH = 4'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        message_start;
		logic [15:0] message_length;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       is_header;
		logic       run_error;
		logic       last_of_item;
	} result_t;

	typedef struct packed {
		logic [4:0]                      length_bits;
		logic signed [8:0]               length_offset;
		logic [3:0]                      align_bits;
		logic [2:0]                      header_bytes;
		logic [MAX_HEADER_BYTES-1:0][MAP_W-1:0] header_map;
	} cfg_t;

	// One queue entry: the work one accepted item leaves for the back end.
	typedef struct packed {
		logic [7:0]                       data;
		logic                             err;
		logic [HDR_CNT_W-1:0]             hdr_cnt;
		logic [MAX_HEADER_BYTES-1:0][7:0] hdr;
	} entry_t;

	// Builds one header byte; code 0 lands in the MSB.
	function automatic logic [7:0] hdr_byte(input logic [MAP_W-1:0] map,
		input logic [LENGTH_WIDTH-1:0] len);
		logic [7:0] v;
		logic [4:0] code;
		v = '0;
		for (int k = 0; k < 8; k++) begin
			code = map[5*k +: 5];
			if (!code[4])
				v[7-k] = len[code[3:0]];
			else
				v[7-k] = (code == CODE_ONE);
		end
		return v;
	endfunction

endpackage

// File: hdl/lrhp_front.sv
// Front end of the literal run header packer: accepts items, tracks the
// message and run counters, and queues each item's work. Uses lrhp_pkg.
module lrhp_front (
	input  logic            clk,
	input  logic            arst_n,
	input  lrhp_pkg::cfg_t  cfg,
	input  lrhp_pkg::item_t item,
	input  logic            accept,
	output logic            push,
	output lrhp_pkg::entry_t push_entry
);
	import lrhp_pkg::*;

	logic [15:0]        mr_q;
	logic [16:0]        rr_q;
	logic               drop_q;
	logic [15:0]        mr_eff;
	logic [16:0]        rr_eff;
	logic               drop_eff;
	logic signed [17:0] off_ext;
	logic signed [17:0] cnt;
	logic [16:0]        cnt_pos;
	logic [4:0]         lb;
	logic [16:0]        maxlen;
	logic [16:0]        sat;
	logic [15:0]        mask;
	logic [15:0]        len;
	logic signed [17:0] run;
	logic               run_bad;
	logic               idle_msg;
	logic [HDR_CNT_W-1:0] hb;

	always_comb begin
		if (item.message_start) begin
			mr_eff   = item.message_length;
			rr_eff   = '0;
			drop_eff = 1'b0;
		end else begin
			mr_eff   = mr_q;
			rr_eff   = rr_q;
			drop_eff = drop_q;
		end
		idle_msg = drop_eff || (mr_eff == '0);

		off_ext = {{9{cfg.length_offset[8]}}, cfg.length_offset};
		cnt     = $signed({2'b00, mr_eff}) - off_ext;
		cnt_pos = cnt[17] ? '0 : cnt[16:0];
		lb      = (cfg.length_bits > 5'(LENGTH_WIDTH)) ? 5'(LENGTH_WIDTH) : cfg.length_bits;
		maxlen  = (17'd1 << lb) - 17'd1;
		sat     = (cnt_pos > maxlen) ? maxlen : cnt_pos;
		mask    = ~((16'd1 << cfg.align_bits) - 16'd1);
		len     = sat[15:0] & mask;
		run     = $signed({2'b00, len}) + off_ext;
		run_bad = run[17] || (run == '0) || (run[16:0] > {1'b0, mr_eff});

		if (cfg.header_bytes == '0)
			hb = HDR_CNT_W'(1);
		else if (cfg.header_bytes > 3'(MAX_HEADER_BYTES))
			hb = HDR_CNT_W'(MAX_HEADER_BYTES);
		else
			hb = HDR_CNT_W'(cfg.header_bytes);

		push_entry.data    = item.data_byte;
		push_entry.err     = 1'b0;
		push_entry.hdr_cnt = '0;
		for (int b = 0; b < MAX_HEADER_BYTES; b++)
			push_entry.hdr[b] = hdr_byte(cfg.header_map[b], len);
		if (rr_eff == '0) begin
			if (run_bad)
				push_entry.err = 1'b1;
			else
				push_entry.hdr_cnt = hb;
		end
		push = accept && !idle_msg;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mr_q   <= '0;
			rr_q   <= '0;
			drop_q <= 1'b0;
		end else if (accept) begin
			if (idle_msg) begin
				mr_q   <= mr_eff;
				rr_q   <= rr_eff;
				drop_q <= drop_eff;
			end else if (rr_eff == '0 && run_bad) begin
				mr_q   <= '0;
				rr_q   <= '0;
				drop_q <= 1'b1;
			end else begin
				mr_q   <= mr_eff - 16'd1;
				rr_q   <= ((rr_eff == '0) ? run[16:0] : rr_eff) - 17'd1;
				drop_q <= 1'b0;
			end
		end
	end

endmodule

// File: hdl/lrhp_queue.sv
// Short FIFO of queue entries between front and back of the packer.
// Register based; uses lrhp_pkg.
module lrhp_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  lrhp_pkg::entry_t  push_entry,
	output logic              full,
	output logic              head_valid,
	output lrhp_pkg::entry_t  head,
	input  logic              pop
);
	import lrhp_pkg::*;

	entry_t            slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full       = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (push && !pop)
				count_q <= count_q + QCNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - QCNT_W'(1);
		end
	end

endmodule

// File: hdl/lrhp_back.sv
// Back end of the packer: sends each entry's header bytes and then its
// literal byte, or its error result, via an output register. Uses lrhp_pkg.
module lrhp_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              head_valid,
	input  lrhp_pkg::entry_t  head,
	output logic              pop,
	output logic              result_valid,
	output lrhp_pkg::result_t result,
	input  logic              result_stall
);
	import lrhp_pkg::*;

	logic                 out_valid_q;
	result_t              out_q;
	logic [HDR_CNT_W-1:0] idx_q;
	logic                 load;
	logic                 in_hdr;
	result_t              next_res;

	assign load   = head_valid && (!out_valid_q || !result_stall);
	assign in_hdr = !head.err && (idx_q < head.hdr_cnt);

	always_comb begin
		next_res.out_byte     = head.data;
		next_res.is_header    = 1'b0;
		next_res.run_error    = 1'b0;
		next_res.last_of_item = 1'b1;
		if (head.err) begin
			next_res.out_byte  = '0;
			next_res.run_error = 1'b1;
		end else if (in_hdr) begin
			next_res.out_byte     = head.hdr[idx_q[$clog2(MAX_HEADER_BYTES > 1 ?
				MAX_HEADER_BYTES : 2)-1:0]];
			next_res.is_header    = 1'b1;
			next_res.last_of_item = 1'b0;
		end
		pop = load && !in_hdr;
	end

	always_ff @(posedge clk) begin
		if (load)
			out_q <= next_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (load)
				out_valid_q <= 1'b1;
			else if (!result_stall)
				out_valid_q <= 1'b0;
			if (load)
				idx_q <= in_hdr ? idx_q + HDR_CNT_W'(1) : '0;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

// File: hdl/literal_run_header_packer.sv
// Top level of the literal run header packer.
// Instantiates lrhp_front, lrhp_queue and lrhp_back; uses lrhp_pkg.

// The packer takes one literal byte per transaction and sends it on,
// preceded by 1 to 4 header bytes whenever that byte opens a new run of the
// message. A byte that falls outside a message, or after a bad run, is
// swallowed without a result; a bad run yields a single error result. The
// front end decides each byte's work in the cycle it is accepted and drops
// it into a four-entry queue; the back end drains the queue at one result
// per cycle through a registered output, unless result_stall holds it. A
// byte inside a run yields one result; a byte that opens a run yields its
// header bytes, then its literal byte. The input side stalls only when the
// queue is full. Accepted work passes a queue slot register and then the
// output register. Configuration writes are always taken (cfg_ready is
// tied high) and are meant to happen while no transaction is in flight.
module literal_run_header_packer (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_stall,
	input  lrhp_pkg::item_t                     item,
	output logic                                result_valid,
	input  logic                                result_stall,
	output lrhp_pkg::result_t                   result,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [lrhp_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [lrhp_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import lrhp_pkg::*;

	cfg_t   cfg_q;
	logic   accept;
	logic   push;
	entry_t push_entry;
	logic   full;
	logic   head_valid;
	entry_t head;
	logic   pop;

	// Register file. Writes to indexes past the last register are ignored.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.length_bits   <= 5'd8;
			cfg_q.length_offset <= '0;
			cfg_q.align_bits    <= '0;
			cfg_q.header_bytes  <= 3'd1;
			cfg_q.header_map    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_LENGTH_BITS:       cfg_q.length_bits   <= cfg_data[4:0];
				REG_LENGTH_OFFSET:     cfg_q.length_offset <= cfg_data[8:0];
				REG_ALIGN_BITS:        cfg_q.align_bits    <= cfg_data[3:0];
				REG_HEADER_BYTES:      cfg_q.header_bytes  <= cfg_data[2:0];
				REG_HEADER_MAP_FIRST:  cfg_q.header_map[0] <= cfg_data[MAP_W-1:0];
				REG_HEADER_MAP_SECOND: cfg_q.header_map[1] <= cfg_data[MAP_W-1:0];
				REG_HEADER_MAP_THIRD:  cfg_q.header_map[2] <= cfg_data[MAP_W-1:0];
				REG_HEADER_MAP_FOURTH: cfg_q.header_map[3] <= cfg_data[MAP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// The input stalls only on a full queue, so a stream of run bytes flows
	// at one per cycle while the output keeps up.
	assign item_stall = full;
	assign accept     = item_valid && !item_stall;

	lrhp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item       (item),
		.accept     (accept),
		.push       (push),
		.push_entry (push_entry)
	);

	lrhp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (full),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	lrhp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head         (head),
		.pop          (pop),
		.result_valid (result_valid),
		.result       (result),
		.result_stall (result_stall)
	);

endmodule

// File: hdl/lrhp_checker.sv
// Port level checks for the literal run header packer, bound to the top.
// Uses lrhp_pkg for the payload types.
module lrhp_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             result_valid,
	input  logic                             result_stall,
	input  lrhp_pkg::result_t                result,
	input  logic                             cfg_ready
);
	import lrhp_pkg::*;

	// An error result stands alone and carries no byte.
	a_error_shape: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.run_error |->
			result.last_of_item && !result.is_header && (result.out_byte == 8'd0))
		else $error("error result with unexpected fields");

	// A header byte is never marked as the last result of its item.
	a_header_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.is_header |-> !result.last_of_item)
		else $error("header byte marked as last of item");

	// After a header byte is taken, the next result is another header or a
	// literal byte, never an error.
	a_header_then_data: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_stall && result.is_header ##1 result_valid |->
			!result.run_error)
		else $error("error result inside a header sequence");

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result changed");

	// The register port never pushes back.
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("configuration port not ready");

endmodule

bind literal_run_header_packer lrhp_checker u_lrhp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result),
	.cfg_ready    (cfg_ready)
);
